// ===== src/hfr_pkg.sv =====
// ----------------------------------------------------------------------------
// hfr_pkg: shared types and constants of the short-frame receiver
// Item structs, parse phases, reply codes and frame constants.
// ----------------------------------------------------------------------------
package hfr_pkg;

  // store size and derived widths
  localparam int STORE_DEPTH    = 256;
  localparam int MAX_DATA_BYTES = 25;
  localparam int CNT_W          = $clog2(STORE_DEPTH + 1);
  localparam int IDX_W          = $clog2(STORE_DEPTH);

  // frame constants
  localparam logic [7:0] PREAMBLE_BYTE = 8'hFF;
  localparam logic [7:0] DELIM_SHORT   = 8'h06;
  localparam int         MIN_FRAME     = 8;
  localparam int         MIN_AFTER_PRE = 5;
  localparam logic [7:0] CMD_SET_ADDR  = 8'd6;
  localparam logic [7:0] ADDR_MAX      = 8'd15;

  // address reply status bytes
  localparam logic [7:0] ST_OK       = 8'd0;
  localparam logic [7:0] ST_INTERNAL = 8'd2;
  localparam logic [7:0] ST_RANGE    = 8'd32;

  typedef enum logic [2:0] {
    KIND_DROP = 3'd0,
    KIND_LEN  = 3'd1,
    KIND_CSUM = 3'd2,
    KIND_CMD  = 3'd3,
    KIND_ADDR = 3'd4
  } reply_kind_t;

  // byte-by-byte parse phase
  typedef enum logic [3:0] {
    PH_FIRST,
    PH_PRE,
    PH_ADDR,
    PH_CMD,
    PH_LEN,
    PH_DATA,
    PH_CHECK,
    PH_DONE,
    PH_DEAD
  } phase_t;

  typedef struct packed {
    logic       req_type;
    logic [7:0] rx_byte;
    logic       flash_ok;
  } hfr_in_t;

  typedef struct packed {
    logic [2:0] reply_kind;
    logic [7:0] reply_status;
    logic [7:0] reply_address;
    logic [7:0] reply_command;
    logic [7:0] good_frames;
  } hfr_out_t;

  // parser status seen by the verdict logic
  typedef struct packed {
    logic [CNT_W-1:0] count;
    phase_t           phase;
    logic [IDX_W-1:0] delim_idx;
    logic [7:0]       command;
    logic [7:0]       length;
    logic [7:0]       xsum;
    logic [7:0]       check;
    logic [7:0]       first_data;
  } hfr_parse_t;

endpackage

// ===== src/hfr_parse.sv =====
// ----------------------------------------------------------------------------
// hfr_parse: on-the-fly frame parser
// Walks preamble, delimiter, address, command, length, data and check byte
// as bytes arrive, keeping the byte count and the running XOR.
// ----------------------------------------------------------------------------
module hfr_parse (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               byte_en,
  input  logic               clear,
  input  logic [7:0]         rx_byte,
  input  logic [7:0]         dev_addr,
  output hfr_pkg::hfr_parse_t st
);
  import hfr_pkg::*;

  phase_t           phase_r, phase_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [IDX_W-1:0] delim_idx_r, delim_idx_nxt;
  logic [7:0]       cmd_r, cmd_nxt;
  logic [7:0]       len_r, len_nxt;
  logic [7:0]       xsum_r, xsum_nxt;
  logic [7:0]       check_r, check_nxt;
  logic [7:0]       first_r, first_nxt;
  logic [7:0]       seen_r, seen_nxt;
  logic             take;
  logic             last_data;

  // bytes past a full store are ignored
  assign take      = byte_en && (count_r != CNT_W'(STORE_DEPTH));
  assign last_data = ({1'b0, seen_r} + 9'd1) == {1'b0, len_r};

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    if (clear) begin
      phase_nxt = PH_FIRST;
    end else if (take) begin
      case (phase_r)
        PH_FIRST: phase_nxt = (rx_byte == PREAMBLE_BYTE) ? PH_PRE : PH_DEAD;
        PH_PRE: begin
          if (rx_byte != PREAMBLE_BYTE) begin
            phase_nxt = (rx_byte == DELIM_SHORT) ? PH_ADDR : PH_DEAD;
          end
        end
        PH_ADDR:  phase_nxt = (rx_byte == dev_addr) ? PH_CMD : PH_DEAD;
        PH_CMD:   phase_nxt = PH_LEN;
        PH_LEN:   phase_nxt = (rx_byte == 8'd0) ? PH_CHECK : PH_DATA;
        PH_DATA:  phase_nxt = last_data ? PH_CHECK : PH_DATA;
        PH_CHECK: phase_nxt = PH_DONE;
        default:  phase_nxt = phase_r;
      endcase
    end
  end

  // field capture and running xor
  always_comb begin
    count_nxt     = count_r;
    delim_idx_nxt = delim_idx_r;
    cmd_nxt       = cmd_r;
    len_nxt       = len_r;
    xsum_nxt      = xsum_r;
    check_nxt     = check_r;
    first_nxt     = first_r;
    seen_nxt      = seen_r;
    if (clear) begin
      count_nxt = '0;
    end else if (take) begin
      count_nxt = count_r + CNT_W'(1);
      case (phase_r)
        PH_PRE: begin
          delim_idx_nxt = count_r[IDX_W-1:0];
          xsum_nxt      = rx_byte;
        end
        PH_ADDR: xsum_nxt = xsum_r ^ rx_byte;
        PH_CMD: begin
          cmd_nxt  = rx_byte;
          xsum_nxt = xsum_r ^ rx_byte;
        end
        PH_LEN: begin
          len_nxt  = rx_byte;
          xsum_nxt = xsum_r ^ rx_byte;
          seen_nxt = 8'd0;
        end
        PH_DATA: begin
          if (seen_r == 8'd0) begin
            first_nxt = rx_byte;
          end
          xsum_nxt = xsum_r ^ rx_byte;
          seen_nxt = seen_r + 8'd1;
        end
        PH_CHECK: check_nxt = rx_byte;
        default: ;
      endcase
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_FIRST;
      count_r <= '0;
    end else begin
      phase_r <= phase_nxt;
      count_r <= count_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    delim_idx_r <= delim_idx_nxt;
    cmd_r       <= cmd_nxt;
    len_r       <= len_nxt;
    xsum_r      <= xsum_nxt;
    check_r     <= check_nxt;
    first_r     <= first_nxt;
    seen_r      <= seen_nxt;
  end

  // status out
  always_comb begin
    st.count      = count_r;
    st.phase      = phase_r;
    st.delim_idx  = delim_idx_r;
    st.command    = cmd_r;
    st.length     = len_r;
    st.xsum       = xsum_r;
    st.check      = check_r;
    st.first_data = first_r;
  end

endmodule

// ===== src/hart_frame_receiver.sv =====
// ----------------------------------------------------------------------------
// hart_frame_receiver: short-frame receiver with address-change command
// Parses received bytes as they arrive and gives one verdict per burst.
// ----------------------------------------------------------------------------
// One item is taken every cycle while the input is not stalled. Bytes are
// parsed as they arrive, so a pause item is judged in the same cycle it is
// accepted. Results pass through an output register backed by a one-entry
// skid stage, which takes a result while the output register still holds one;
// the input stalls only while both hold results. There is no clearing pass after reset.
module hart_frame_receiver (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  hfr_pkg::hfr_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output hfr_pkg::hfr_out_t out_data
);
  import hfr_pkg::*;

  hfr_parse_t st;
  logic       acc;
  logic       byte_en;
  logic       pause;
  logic       res;

  logic [7:0] dev_addr_r, dev_addr_nxt;
  logic [7:0] good_r, good_nxt;
  logic [7:0] fdb_r, fdb_nxt;

  hfr_out_t   result;
  hfr_out_t   out_r, skid_r;
  logic       out_valid_r, skid_valid_r;
  logic       take_out;

  reply_kind_t      kind;
  logic [7:0]       status;
  logic [7:0]       command;
  logic [7:0]       new_addr;
  logic             size_ok;
  logic             tail_short;
  logic             past_header;
  logic [CNT_W-1:0] tail;

  assign in_stall = skid_valid_r;
  assign acc      = in_valid && !in_stall;
  assign byte_en  = acc && !in_data.req_type;
  assign pause    = acc && in_data.req_type;
  assign res      = pause && (st.count != '0);

  hfr_parse u_parse (
    .clk      (clk),
    .rst_n    (rst_n),
    .byte_en  (byte_en),
    .clear    (pause),
    .rx_byte  (in_data.rx_byte),
    .dev_addr (dev_addr_r),
    .st       (st)
  );

  // frame verdict
  assign size_ok     = (st.count >= CNT_W'(MIN_FRAME)) &&
                       (st.count != CNT_W'(STORE_DEPTH));
  assign tail        = st.count - {{(CNT_W-IDX_W){1'b0}}, st.delim_idx};
  assign tail_short  = (st.delim_idx >= IDX_W'(2)) && (tail < CNT_W'(MIN_AFTER_PRE));
  assign past_header = (st.phase == PH_DATA) || (st.phase == PH_CHECK) ||
                       (st.phase == PH_DONE);
  assign new_addr    = (st.length != 8'd0) ? st.first_data : fdb_r;

  always_comb begin
    kind         = KIND_DROP;
    status       = ST_OK;
    command      = 8'd0;
    dev_addr_nxt = dev_addr_r;
    good_nxt     = good_r;
    fdb_nxt      = fdb_r;
    if (size_ok && past_header && !tail_short) begin
      command = st.command;
      if ((st.length > 8'(MAX_DATA_BYTES)) || (st.phase != PH_DONE)) begin
        kind = KIND_LEN;
      end else begin
        if (st.length != 8'd0) begin
          fdb_nxt = st.first_data;
        end
        if (st.check != st.xsum) begin
          kind = KIND_CSUM;
        end else begin
          good_nxt = good_r + 8'd1;
          if (st.command != CMD_SET_ADDR) begin
            kind = KIND_CMD;
          end else begin
            kind = KIND_ADDR;
            if (new_addr > ADDR_MAX) begin
              status = ST_RANGE;
            end else if (new_addr != dev_addr_r) begin
              if (in_data.flash_ok) begin
                dev_addr_nxt = new_addr;
              end else begin
                status = ST_INTERNAL;
              end
            end
          end
        end
      end
    end
  end

  always_comb begin
    result.reply_kind    = kind;
    result.reply_status  = status;
    result.reply_address = dev_addr_nxt;
    result.reply_command = command;
    result.good_frames   = good_nxt;
  end

  // device state, committed on a judged pause
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_addr_r <= 8'd0;
      good_r     <= 8'd0;
      fdb_r      <= 8'd0;
    end else if (res) begin
      dev_addr_r <= dev_addr_nxt;
      good_r     <= good_nxt;
      fdb_r      <= fdb_nxt;
    end
  end

  // output register with skid stage
  assign take_out = out_valid_r && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (take_out) begin
        skid_valid_r <= 1'b0;
      end
    end else if (res) begin
      if (out_valid_r && !take_out) begin
        skid_valid_r <= 1'b1;
      end else begin
        out_valid_r <= 1'b1;
      end
    end else if (take_out) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (take_out) begin
        out_r <= skid_r;
      end
    end else if (res) begin
      if (out_valid_r && !take_out) begin
        skid_r <= result;
      end else begin
        out_r <= result;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid stage holds an item while output register is empty");

  a_result_from_pause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(pause))
    else $error("result appeared without an accepted pause");

  a_byte_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (byte_en && (st.count != CNT_W'(STORE_DEPTH))) |=>
      (st.count == $past(st.count) + CNT_W'(1)))
    else $error("stored byte not counted");

  a_pause_clears: assert property (@(posedge clk) disable iff (!rst_n)
    pause |=> (st.count == '0))
    else $error("store not emptied by pause");

  a_addr_range: assert property (@(posedge clk) disable iff (!rst_n)
    dev_addr_r <= ADDR_MAX)
    else $error("device address out of range");
`endif

endmodule
